// File: rtl/glr_pkg.sv
// glr_pkg: state codes, character codes, types and the transition function
// of the grammar line recogniser; no dependencies
`default_nettype none

package glr_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned StateW = 4;

  typedef logic [SymW-1:0]   sym_t;
  typedef logic [StateW-1:0] state_t;

  // automaton states
  localparam state_t StStart     = 4'd0;
  localparam state_t StComment   = 4'd1;
  localparam state_t StVarOpen   = 4'd2;
  localparam state_t StVarName   = 4'd3;
  localparam state_t StColon     = 4'd5;
  localparam state_t StRuleBody  = 4'd6;
  localparam state_t StRef       = 4'd7;
  localparam state_t StQuoted    = 4'd8;
  localparam state_t StPercent   = 4'd9;
  localparam state_t StDirective = 4'd10;
  localparam state_t StDirSpace  = 4'd11;
  localparam state_t StDirArg    = 4'd12;

  // character codes
  localparam sym_t ChSlash   = 8'h2F;
  localparam sym_t ChLess    = 8'h3C;
  localparam sym_t ChGreater = 8'h3E;
  localparam sym_t ChPercent = 8'h25;
  localparam sym_t ChColon   = 8'h3A;
  localparam sym_t ChEquals  = 8'h3D;
  localparam sym_t ChQuote   = 8'h22;
  localparam sym_t ChSpace   = 8'h20;

  typedef struct packed {
    logic   ok;
    state_t nxt;
  } move_t;

  // exact-symbol move first, then the state's wildcard move
  function automatic move_t glr_move(state_t cur, sym_t c);
    move_t m;
    m.ok  = 1'b1;
    m.nxt = StStart;
    case (cur)
      StStart: begin
        if (c == ChSlash)        m.nxt = StComment;
        else if (c == ChLess)    m.nxt = StVarOpen;
        else if (c == ChPercent) m.nxt = StDirective;
        else                     m.ok  = 1'b0;
      end
      StComment:  m.nxt = StComment;
      StVarOpen: begin
        if (c == ChGreater) m.nxt = StVarName;
        else                m.nxt = StVarOpen;
      end
      StVarName: begin
        if (c == ChSpace)      m.nxt = StVarName;
        else if (c == ChColon) m.nxt = StColon;
        else                   m.ok  = 1'b0;
      end
      StColon: begin
        if (c == ChEquals) m.nxt = StRuleBody;
        else               m.ok  = 1'b0;
      end
      StRuleBody: begin
        if (c == ChSpace)        m.nxt = StRuleBody;
        else if (c == ChLess)    m.nxt = StRef;
        else if (c == ChQuote)   m.nxt = StQuoted;
        else if (c == ChPercent) m.nxt = StPercent;
        else                     m.ok  = 1'b0;
      end
      StRef: begin
        if (c == ChGreater) m.nxt = StRuleBody;
        else                m.nxt = StRef;
      end
      StQuoted: begin
        if (c == ChQuote) m.nxt = StRuleBody;
        else              m.nxt = StQuoted;
      end
      StPercent: begin
        if (c == ChSpace) m.nxt = StRuleBody;
        else              m.nxt = StPercent;
      end
      StDirective: begin
        if (c == ChSpace) m.nxt = StDirSpace;
        else              m.nxt = StDirective;
      end
      StDirSpace: begin
        if (c == ChSpace) m.nxt = StDirSpace;
        else              m.nxt = StDirArg;
      end
      StDirArg:   m.nxt = StDirArg;
      default:    m.ok  = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic glr_accepting(state_t s);
    return s inside {StComment, StRuleBody, StPercent, StDirArg};
  endfunction

endpackage

`default_nettype wire

// File: rtl/glr_if.sv
// glr_if: valid/ready channel interfaces for character words and result words
// depends on glr_pkg
`default_nettype none

interface glr_in_if;
  logic              valid;
  logic              ready;
  glr_pkg::sym_t     symbol;
  logic              end_of_line;

  modport source (output valid, output symbol, output end_of_line, input ready);
  modport sink   (input valid, input symbol, input end_of_line, output ready);
endinterface

interface glr_out_if;
  logic              valid;
  logic              ready;
  glr_pkg::state_t   state_code;
  logic              line_dead;
  logic              verdict_valid;
  logic              line_accepted;

  modport source (output valid, output state_code, output line_dead,
                  output verdict_valid, output line_accepted, input ready);
  modport sink   (input valid, input state_code, input line_dead,
                  input verdict_valid, input line_accepted, output ready);
endinterface

`default_nettype wire

// File: rtl/grammar_line_recognizer_core.sv
// grammar_line_recognizer_core: top level of the grammar line recogniser
// depends on glr_pkg and the channel interfaces in glr_if
`default_nettype none

// usage
// - in_chan carries one word per character of a grammar line: symbol is the
//   byte, end_of_line set marks the end of the line (symbol then ignored)
// - out_chan returns exactly one word per input word: the automaton state
//   after the character (0 once the line is dead), the dead flag, and on an
//   end-of-line word verdict_valid with line_accepted
// - the result word is registered: it appears in the cycle after its input word is taken
// - throughput: one word per cycle while the receiver takes each result word;
//   the next state is a single case decode on the state register and the byte
// - the output register is the only buffer: a new word is taken whenever the
//   register is empty or its word is taken in the same cycle
// - when the receiver stalls, the result word holds and in_chan.ready drops
//   until it is taken; no word is lost or repeated
// - reset puts the automaton in the start state, clears the dead flag and
//   empties the output register
// - an end-of-line word restarts the automaton for the next line
module grammar_line_recognizer_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  glr_in_if.sink      in_chan,
  glr_out_if.source   out_chan
);

  // automaton state, kept at the start code while the line is dead
  glr_pkg::state_t cur_r, cur_nxt;
  logic            dead_r, dead_nxt;

  // result register
  logic            out_valid_r;
  glr_pkg::state_t out_state_r, out_state_nxt;
  logic            out_dead_r, out_dead_nxt;
  logic            out_verdict_r, out_verdict_nxt;
  logic            out_acc_r, out_acc_nxt;

  logic            take;
  glr_pkg::move_t  mv;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign take          = in_chan.valid && in_chan.ready;

  assign mv = glr_pkg::glr_move(cur_r, in_chan.symbol);

  always_comb begin
    cur_nxt         = cur_r;
    dead_nxt        = dead_r;
    out_state_nxt   = cur_r;
    out_dead_nxt    = dead_r;
    out_verdict_nxt = 1'b0;
    out_acc_nxt     = 1'b0;
    if (in_chan.end_of_line) begin
      // verdict, then restart for the next line
      out_state_nxt   = cur_r;
      out_dead_nxt    = dead_r;
      out_verdict_nxt = 1'b1;
      out_acc_nxt     = !dead_r && glr_pkg::glr_accepting(cur_r);
      cur_nxt         = glr_pkg::StStart;
      dead_nxt        = 1'b0;
    end else begin
      if (!dead_r) begin
        if (mv.ok) begin
          cur_nxt = mv.nxt;
        end else begin
          // no transition: line is dead from here on
          cur_nxt  = glr_pkg::StStart;
          dead_nxt = 1'b1;
        end
      end
      out_state_nxt = cur_nxt;
      out_dead_nxt  = dead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= glr_pkg::StStart;
      dead_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        cur_r       <= cur_nxt;
        dead_r      <= dead_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      out_state_r   <= out_state_nxt;
      out_dead_r    <= out_dead_nxt;
      out_verdict_r <= out_verdict_nxt;
      out_acc_r     <= out_acc_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.state_code    = out_state_r;
  assign out_chan.line_dead     = out_dead_r;
  assign out_chan.verdict_valid = out_verdict_r;
  assign out_chan.line_accepted = out_acc_r;

endmodule

`default_nettype wire
